FILE: rtl/core/fvt_pkg.sv
// Package: shared types and codes of the frustum visibility test.
`timescale 1ns / 1ps
package fvt_pkg;

    typedef enum logic [2:0] {
        CMD_WR_PLANE    = 3'd0,
        CMD_WR_CORNER   = 3'd1,
        CMD_TEST_POINT  = 3'd2,
        CMD_TEST_SPHERE = 3'd3,
        CMD_TEST_BOX    = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_MIN,
        ST_MUL_MAX,
        ST_SUM,
        ST_FACE,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        VERD_NONE   = 2'd0,
        VERD_INSIDE = 2'd1,
        VERD_BEHIND = 2'd2,
        VERD_FACE   = 2'd3
    } t_verdict;

    localparam int NUM_PLANES  = 6;
    localparam int NUM_CORNERS = 8;
    localparam int FIELD_W     = 32;

    typedef struct packed {
        logic       load;
        logic       sel_max;
        logic       cap_min;
        logic       cap_max;
        logic [2:0] plane_idx;
        logic [1:0] axis;
    } t_dp_cmd;

    typedef struct packed {
        logic behind;
        logic beyond;
    } t_dp_status;

endpackage

FILE: rtl/core/fvt_datapath.sv
// Datapath: plane and corner storage, three multipliers, plane sum and face compare.
`timescale 1ns / 1ps
module fvt_datapath #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  fvt_pkg::t_dp_cmd        i_cmd,
    input  logic [2:0]              i_command,
    input  logic [2:0]              i_slot,
    input  logic [fvt_pkg::FIELD_W-1:0] i_vx,
    input  logic [fvt_pkg::FIELD_W-1:0] i_vy,
    input  logic [fvt_pkg::FIELD_W-1:0] i_vz,
    input  logic [fvt_pkg::FIELD_W-1:0] i_offset,
    input  logic [fvt_pkg::FIELD_W-1:0] i_radius,
    input  logic [fvt_pkg::FIELD_W-1:0] i_max_x,
    input  logic [fvt_pkg::FIELD_W-1:0] i_max_y,
    input  logic [fvt_pkg::FIELD_W-1:0] i_max_z,
    output fvt_pkg::t_dp_status     o_status
);
    import fvt_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int PW = 2 * CW;
    localparam int SW = 2 * CW + FRAC_BITS + 4;

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [PW-1:0] t_prod;

    t_coord r_pn   [NUM_PLANES][3];
    t_coord r_pd   [NUM_PLANES];
    t_coord r_cr   [NUM_CORNERS][3];
    t_coord r_min  [3];
    t_coord r_max  [3];
    t_coord r_rad;
    logic   r_box;
    logic   r_sphere;
    t_prod  r_pa   [3];
    t_prod  r_pb   [3];

    t_coord in_v   [3];
    t_coord in_mx  [3];
    t_prod  prod   [3];
    t_prod  pick   [3];
    logic signed [SW-1:0] sum;
    logic [NUM_CORNERS-1:0] above;
    logic [NUM_CORNERS-1:0] below;

    always_comb begin
        in_v[0]  = CW'($signed(i_vx));
        in_v[1]  = CW'($signed(i_vy));
        in_v[2]  = CW'($signed(i_vz));
        in_mx[0] = CW'($signed(i_max_x));
        in_mx[1] = CW'($signed(i_max_y));
        in_mx[2] = CW'($signed(i_max_z));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                for (int a = 0; a < 3; a++) begin
                    r_pn[p][a] <= '0;
                end
                r_pd[p] <= '0;
            end
            for (int c = 0; c < NUM_CORNERS; c++) begin
                for (int a = 0; a < 3; a++) begin
                    r_cr[c][a] <= '0;
                end
            end
        end else if (i_cmd.load) begin
            if (i_command == CMD_WR_PLANE && i_slot < 3'(NUM_PLANES)) begin
                for (int a = 0; a < 3; a++) begin
                    r_pn[i_slot][a] <= in_v[a];
                end
                r_pd[i_slot] <= CW'($signed(i_offset));
            end else if (i_command == CMD_WR_CORNER) begin
                for (int a = 0; a < 3; a++) begin
                    r_cr[i_slot][a] <= in_v[a];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int a = 0; a < 3; a++) begin
                r_min[a] <= in_v[a];
                r_max[a] <= in_mx[a];
            end
            r_rad    <= CW'($signed(i_radius));
            r_box    <= (i_command == CMD_TEST_BOX);
            r_sphere <= (i_command == CMD_TEST_SPHERE);
        end
        for (int a = 0; a < 3; a++) begin
            if (i_cmd.cap_min) begin
                r_pa[a] <= prod[a];
            end
            if (i_cmd.cap_max) begin
                r_pb[a] <= prod[a];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            prod[a] = PW'(r_pn[i_cmd.plane_idx][a])
                    * PW'(i_cmd.sel_max ? r_max[a] : r_min[a]);
        end
    end

    // Box is fully behind a plane when its most forward corner is behind it.
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            pick[a] = (r_box && r_pb[a] > r_pa[a]) ? r_pb[a] : r_pa[a];
        end
        sum = SW'(pick[0]) + SW'(pick[1]) + SW'(pick[2])
            + (SW'(r_pd[i_cmd.plane_idx]) <<< FRAC_BITS)
            + (r_sphere ? (SW'(r_rad) <<< FRAC_BITS) : SW'(0));
    end

    always_comb begin
        for (int c = 0; c < NUM_CORNERS; c++) begin
            above[c] = r_cr[c][i_cmd.axis] > r_max[i_cmd.axis];
            below[c] = r_cr[c][i_cmd.axis] < r_min[i_cmd.axis];
        end
        o_status.behind = sum[SW-1];
        o_status.beyond = (&above) || (&below);
    end

endmodule

FILE: rtl/core/fvt_ctrl.sv
// Controller: sequences planes and box faces, holds the result register.
`timescale 1ns / 1ps
module fvt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [2:0]           i_command,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic                 o_visible,
    output logic [1:0]           o_verdict,
    output fvt_pkg::t_dp_cmd     o_dp_cmd,
    input  fvt_pkg::t_dp_status  i_dp_status
);
    import fvt_pkg::*;

    t_state   r_state, n_state;
    t_verdict r_verd,  n_verd;
    logic [2:0] r_plane, n_plane;
    logic [1:0] r_axis,  n_axis;
    logic       r_box,   n_box;
    logic       r_out_valid, n_out_valid;
    logic       r_visible,   n_visible;
    logic [1:0] r_out_verd,  n_out_verd;
    logic       accept;
    logic       is_test;
    logic       out_free;

    assign accept   = i_s_tvalid && o_s_tready;
    assign is_test  = (i_command == CMD_TEST_POINT) || (i_command == CMD_TEST_SPHERE)
                   || (i_command == CMD_TEST_BOX);
    assign out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (accept) n_state = is_test ? ST_MUL_MIN : ST_DONE;
            ST_MUL_MIN: n_state = r_box ? ST_MUL_MAX : ST_SUM;
            ST_MUL_MAX: n_state = ST_SUM;
            ST_SUM: begin
                if (i_dp_status.behind) n_state = ST_DONE;
                else if (r_plane == 3'(NUM_PLANES - 1)) n_state = r_box ? ST_FACE : ST_DONE;
                else n_state = ST_MUL_MIN;
            end
            ST_FACE:    if (i_dp_status.beyond || r_axis == 2'd2) n_state = ST_DONE;
            ST_DONE:    if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready       = (r_state == ST_IDLE);
        o_dp_cmd         = '0;
        o_dp_cmd.plane_idx = r_plane;
        o_dp_cmd.axis    = r_axis;
        n_verd           = r_verd;
        n_plane          = r_plane;
        n_axis           = r_axis;
        n_box            = r_box;
        n_out_valid      = r_out_valid && !i_m_tready;
        n_visible        = r_visible;
        n_out_verd       = r_out_verd;
        unique case (r_state)
            ST_IDLE: begin
                o_dp_cmd.load = accept;
                if (accept) begin
                    n_verd  = is_test ? VERD_INSIDE : VERD_NONE;
                    n_box   = (i_command == CMD_TEST_BOX);
                    n_plane = '0;
                    n_axis  = '0;
                end
            end
            ST_MUL_MIN: o_dp_cmd.cap_min = 1'b1;
            ST_MUL_MAX: begin
                o_dp_cmd.sel_max = 1'b1;
                o_dp_cmd.cap_max = 1'b1;
            end
            ST_SUM: begin
                if (i_dp_status.behind) n_verd = VERD_BEHIND;
                n_plane = r_plane + 3'd1;
            end
            ST_FACE: begin
                if (i_dp_status.beyond) n_verd = VERD_FACE;
                n_axis = r_axis + 2'd1;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_visible   = (r_verd == VERD_INSIDE);
                    n_out_verd  = r_verd;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_verd      <= VERD_NONE;
            r_plane     <= '0;
            r_axis      <= '0;
            r_box       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_verd      <= n_verd;
            r_plane     <= n_plane;
            r_axis      <= n_axis;
            r_box       <= n_box;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_visible  <= n_visible;
        r_out_verd <= n_out_verd;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_visible  = r_visible;
    assign o_verdict  = r_out_verd;

endmodule

FILE: rtl/core/frustum_visibility_test.sv
// Top level: frustum visibility test for points, spheres and boxes.
`timescale 1ns / 1ps
// A write goes straight to the done state. A point or sphere test has a
// multiply and a sum state per plane, a box test min and max multiply
// states and a sum state per plane plus a face check per axis; the three
// shared multipliers step through the six planes. Tests stop at the
// first failing plane or face. One item is in work at a time; a finished
// result waits in the output register while the next item is taken.
module frustum_visibility_test #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // vx, vy, vz, plane_offset, radius, max_x, max_y, max_z (32 bits each)
    input  logic [255:0] s_tdata,
    // command [2:0], slot [5:3]
    input  logic [5:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // visible [0], zero fill above
    output logic [7:0]   m_tdata,
    // verdict [1:0]
    output logic [1:0]   m_tuser
);
    import fvt_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       visible;

    fvt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_command   (s_tuser[2:0]),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_visible   (visible),
        .o_verdict   (m_tuser),
        .o_dp_cmd    (dp_cmd),
        .i_dp_status (dp_status)
    );

    fvt_datapath #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .i_command (s_tuser[2:0]),
        .i_slot    (s_tuser[5:3]),
        .i_vx      (s_tdata[31:0]),
        .i_vy      (s_tdata[63:32]),
        .i_vz      (s_tdata[95:64]),
        .i_offset  (s_tdata[127:96]),
        .i_radius  (s_tdata[159:128]),
        .i_max_x   (s_tdata[191:160]),
        .i_max_y   (s_tdata[223:192]),
        .i_max_z   (s_tdata[255:224]),
        .o_status  (dp_status)
    );

    assign m_tdata = {7'd0, visible};

endmodule
